/* sv/render_scale_budget_governor_unit_assert.svh */
// ----------------------------------------------------------------------------
// Render scale budget governor: assertion macros
// Implication checks sampled on the rising clock edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RENDER_SCALE_BUDGET_GOVERNOR_UNIT_ASSERT_SVH
`define RENDER_SCALE_BUDGET_GOVERNOR_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RSBG_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rsbg assertion failed");
`define RSBG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rsbg assertion failed");
`else
`define RSBG_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RSBG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* sv/rsbg_pkg.sv */
// ----------------------------------------------------------------------------
// Render scale budget governor package
// Shared types, codes and helper functions.
// ----------------------------------------------------------------------------
package rsbg_pkg;

   localparam logic [12:0] SCALE_FLOOR = 13'd410;
   localparam logic [12:0] SCALE_ONE   = 13'd4096;
   localparam logic [12:0] STEP_FLOOR  = 13'd4;
   localparam logic [12:0] STEP_RESET  = 13'd205;

   localparam logic [1:0] MODE_DISABLED = 2'd0;
   localparam logic [1:0] MODE_LOCKED   = 2'd1;
   localparam logic [1:0] MODE_ACTIVE   = 2'd2;

   localparam logic ACT_SAMPLE  = 1'b0;
   localparam logic ACT_RESTART = 1'b1;

   localparam logic [1:0] DEC_KEEP     = 2'd0;
   localparam logic [1:0] DEC_DECREASE = 2'd1;
   localparam logic [1:0] DEC_INCREASE = 2'd2;
   localparam logic [1:0] DEC_DEGRADE  = 2'd3;

   localparam logic [3:0] CAUSE_STABLE    = 4'd0;
   localparam logic [3:0] CAUSE_DISABLED  = 4'd1;
   localparam logic [3:0] CAUSE_LOCKED    = 4'd2;
   localparam logic [3:0] CAUSE_INVALID   = 4'd3;
   localparam logic [3:0] CAUSE_WAIT_DOWN = 4'd4;
   localparam logic [3:0] CAUSE_WAIT_UP   = 4'd5;
   localparam logic [3:0] CAUSE_COOLDOWN  = 4'd6;
   localparam logic [3:0] CAUSE_AT_MIN    = 4'd7;
   localparam logic [3:0] CAUSE_AT_MAX    = 4'd8;
   localparam logic [3:0] CAUSE_DECREASED = 4'd9;
   localparam logic [3:0] CAUSE_INCREASED = 4'd10;
   localparam logic [3:0] CAUSE_DEGRADE   = 4'd11;

   localparam logic [2:0] REG_MODE      = 3'd0;
   localparam logic [2:0] REG_DOWN_THR  = 3'd1;
   localparam logic [2:0] REG_UP_THR    = 3'd2;
   localparam logic [2:0] REG_MIN_SCALE = 3'd3;
   localparam logic [2:0] REG_MAX_SCALE = 3'd4;
   localparam logic [2:0] REG_STEP      = 3'd5;
   localparam logic [2:0] REG_SUSTAIN   = 3'd6;
   localparam logic [2:0] REG_COOLDOWN  = 3'd7;

   typedef struct packed {
      logic        action;
      logic        sample_valid;
      logic [19:0] frame_time_us;
      logic [31:0] frame_index;
      logic [47:0] now_us;
   } req_type;

   typedef struct packed {
      logic [1:0]  decision;
      logic [3:0]  cause;
      logic [12:0] previous_scale;
      logic [12:0] new_scale;
      logic [31:0] echoed_frame_index;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [19:0] down_threshold_us;
      logic [19:0] up_threshold_us;
      logic [12:0] lo;
      logic [12:0] hi;
      logic [12:0] step;
      logic [31:0] sustain_us;
      logic [31:0] cooldown_us;
   } cfg_type;

   // signed elapsed time below span; a negative difference counts as below
   function automatic logic elapsed_below(input logic [47:0] now, input logic [47:0] since,
                                          input logic [31:0] span);
      logic [48:0] d;
      d = {1'b0, now} - {1'b0, since};
      return d[48] || (d[47:0] < {16'd0, span});
   endfunction

   function automatic logic [12:0] clamp13(input logic [12:0] v, input logic [12:0] lo,
                                           input logic [12:0] hi);
      logic [12:0] r;
      r = v;
      if (v < lo) begin
         r = lo;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

/* sv/rsbg_if.sv */
// ----------------------------------------------------------------------------
// Render scale budget governor channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface rsbg_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic        sample_valid;
   logic [19:0] frame_time_us;
   logic [31:0] frame_index;
   logic [47:0] now_us;

   modport source (output valid, output action, output sample_valid, output frame_time_us,
                   output frame_index, output now_us, input ready);
   modport sink   (input valid, input action, input sample_valid, input frame_time_us,
                   input frame_index, input now_us, output ready);
endinterface

interface rsbg_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  decision;
   logic [3:0]  cause;
   logic [12:0] previous_scale;
   logic [12:0] new_scale;
   logic [31:0] echoed_frame_index;

   modport source (output valid, output decision, output cause, output previous_scale,
                   output new_scale, output echoed_frame_index, input ready);
   modport sink   (input valid, input decision, input cause, input previous_scale,
                   input new_scale, input echoed_frame_index, output ready);
endinterface

/* sv/rsbg_csr.sv */
// ----------------------------------------------------------------------------
// Render scale budget governor registers
// Holds the configuration registers and registers their normalised limits.
// ----------------------------------------------------------------------------
module rsbg_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output rsbg_pkg::cfg_type  cfg
);
   import rsbg_pkg::*;

   logic [1:0]  mode_ff;
   logic [19:0] down_thr_ff;
   logic [19:0] up_thr_ff;
   logic [12:0] min_scale_ff;
   logic [12:0] max_scale_ff;
   logic [12:0] step_ff;
   logic [31:0] sustain_ff;
   logic [31:0] cooldown_ff;
   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   logic [12:0] span;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_DISABLED;
         down_thr_ff  <= '0;
         up_thr_ff    <= '0;
         min_scale_ff <= SCALE_FLOOR;
         max_scale_ff <= SCALE_ONE;
         step_ff      <= STEP_RESET;
         sustain_ff   <= '0;
         cooldown_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_MODE:      mode_ff      <= csr_wdata[1:0];
            REG_DOWN_THR:  down_thr_ff  <= csr_wdata[19:0];
            REG_UP_THR:    up_thr_ff    <= csr_wdata[19:0];
            REG_MIN_SCALE: min_scale_ff <= csr_wdata[12:0];
            REG_MAX_SCALE: max_scale_ff <= csr_wdata[12:0];
            REG_STEP:      step_ff      <= csr_wdata[12:0];
            REG_SUSTAIN:   sustain_ff   <= csr_wdata;
            REG_COOLDOWN:  cooldown_ff  <= csr_wdata;
            default:       mode_ff      <= mode_ff;
         endcase
      end
   end

   always_comb begin
      cfg_in.mode              = mode_ff;
      cfg_in.down_threshold_us = down_thr_ff;
      cfg_in.up_threshold_us   = up_thr_ff;
      cfg_in.sustain_us        = sustain_ff;
      cfg_in.cooldown_us       = cooldown_ff;
      cfg_in.lo                = clamp13(min_scale_ff, SCALE_FLOOR, SCALE_ONE);
      cfg_in.hi                = clamp13(max_scale_ff, cfg_in.lo, SCALE_ONE);
      span                     = cfg_in.hi - cfg_in.lo + STEP_FLOOR;
      cfg_in.step              = clamp13(step_ff, STEP_FLOOR, span);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{mode: MODE_DISABLED, down_threshold_us: '0, up_threshold_us: '0,
                     lo: SCALE_FLOOR, hi: SCALE_ONE, step: STEP_RESET,
                     sustain_us: '0, cooldown_us: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/rsbg_governor.sv */
// ----------------------------------------------------------------------------
// Render scale budget governor decision stage
// Classifies one registered beat, decides the scale step and updates state.
// ----------------------------------------------------------------------------
module rsbg_governor (
   input  logic               clock,
   input  logic               reset,
   input  rsbg_pkg::cfg_type  cfg,
   input  logic               fire,
   input  rsbg_pkg::req_type  item,
   output rsbg_pkg::rsp_type  result
);
   import rsbg_pkg::*;

   logic [12:0] scale_ff,       scale_in;
   logic [47:0] over_start_ff,  over_start_in;
   logic        over_active_ff, over_active_in;
   logic [47:0] under_start_ff, under_start_in;
   logic        under_active_ff, under_active_in;
   logic [47:0] last_change_ff, last_change_in;
   logic [31:0] last_frame_ff,  last_frame_in;
   logic        degrade_ff,     degrade_in;

   logic [47:0] over_since;
   logic [47:0] under_since;
   logic        over_wait;
   logic        under_wait;
   logic        cool_wait;
   logic        invalid;
   logic        over;
   logic        under;
   logic [13:0] diff;
   logic [13:0] sum;
   logic [12:0] dec_scale;
   logic [12:0] inc_scale;
   logic [1:0]  decision;
   logic [3:0]  cause;

   always_comb begin
      over_since  = over_active_ff ? over_start_ff : item.now_us;
      under_since = under_active_ff ? under_start_ff : item.now_us;
      over_wait   = elapsed_below(item.now_us, over_since, cfg.sustain_us);
      under_wait  = elapsed_below(item.now_us, under_since, cfg.sustain_us);
      cool_wait   = elapsed_below(item.now_us, last_change_ff, cfg.cooldown_us);

      invalid = !item.sample_valid || (item.frame_time_us == '0) ||
                ((item.frame_index != '0) && (item.frame_index == last_frame_ff));
      over    = (cfg.down_threshold_us != '0) && (item.frame_time_us > cfg.down_threshold_us);
      under   = (cfg.up_threshold_us != '0) && (item.frame_time_us < cfg.up_threshold_us);

      diff = {1'b0, scale_ff} - {1'b0, cfg.step};
      if (diff[13] || (diff[12:0] < cfg.lo)) begin
         dec_scale = cfg.lo;
      end else if (diff[12:0] > cfg.hi) begin
         dec_scale = cfg.hi;
      end else begin
         dec_scale = diff[12:0];
      end

      sum = {1'b0, scale_ff} + {1'b0, cfg.step};
      if (sum < {1'b0, cfg.lo}) begin
         inc_scale = cfg.lo;
      end else if (sum > {1'b0, cfg.hi}) begin
         inc_scale = cfg.hi;
      end else begin
         inc_scale = sum[12:0];
      end

      scale_in        = scale_ff;
      over_start_in   = over_start_ff;
      over_active_in  = over_active_ff;
      under_start_in  = under_start_ff;
      under_active_in = under_active_ff;
      last_change_in  = last_change_ff;
      last_frame_in   = last_frame_ff;
      degrade_in      = degrade_ff;
      decision        = DEC_KEEP;
      cause           = CAUSE_STABLE;

      if (item.action == ACT_RESTART) begin
         over_active_in  = 1'b0;
         under_active_in = 1'b0;
         last_change_in  = item.now_us;
         last_frame_in   = '0;
         degrade_in      = 1'b0;
      end else begin
         case (cfg.mode)
            MODE_LOCKED: begin
               cause = CAUSE_LOCKED;
            end
            MODE_ACTIVE: begin
               if (invalid) begin
                  cause = CAUSE_INVALID;
               end else begin
                  if (item.frame_index != '0) begin
                     last_frame_in = item.frame_index;
                  end
                  if (over) begin
                     over_active_in  = 1'b1;
                     over_start_in   = over_since;
                     under_active_in = 1'b0;
                     if (over_wait) begin
                        cause = CAUSE_WAIT_DOWN;
                     end else if (cool_wait) begin
                        cause = CAUSE_COOLDOWN;
                     end else if (scale_ff > cfg.lo) begin
                        scale_in       = dec_scale;
                        last_change_in = item.now_us;
                        degrade_in     = 1'b0;
                        over_start_in  = item.now_us;
                        decision       = DEC_DECREASE;
                        cause          = CAUSE_DECREASED;
                     end else if (!degrade_ff) begin
                        degrade_in     = 1'b1;
                        last_change_in = item.now_us;
                        decision       = DEC_DEGRADE;
                        cause          = CAUSE_DEGRADE;
                     end else begin
                        cause = CAUSE_AT_MIN;
                     end
                  end else if (under) begin
                     under_active_in = 1'b1;
                     under_start_in  = under_since;
                     over_active_in  = 1'b0;
                     if (under_wait) begin
                        cause = CAUSE_WAIT_UP;
                     end else if (cool_wait) begin
                        cause = CAUSE_COOLDOWN;
                     end else if (scale_ff < cfg.hi) begin
                        scale_in       = inc_scale;
                        last_change_in = item.now_us;
                        degrade_in     = 1'b0;
                        under_start_in = item.now_us;
                        decision       = DEC_INCREASE;
                        cause          = CAUSE_INCREASED;
                     end else begin
                        cause = CAUSE_AT_MAX;
                     end
                  end else begin
                     over_active_in  = 1'b0;
                     under_active_in = 1'b0;
                  end
               end
            end
            default: begin
               cause = CAUSE_DISABLED;
            end
         endcase
      end

      result.decision           = decision;
      result.cause              = cause;
      result.previous_scale     = scale_ff;
      result.new_scale          = scale_in;
      result.echoed_frame_index = item.frame_index;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff        <= SCALE_ONE;
         over_start_ff   <= '0;
         over_active_ff  <= 1'b0;
         under_start_ff  <= '0;
         under_active_ff <= 1'b0;
         last_change_ff  <= '0;
         last_frame_ff   <= '0;
         degrade_ff      <= 1'b0;
      end else if (fire) begin
         scale_ff        <= scale_in;
         over_start_ff   <= over_start_in;
         over_active_ff  <= over_active_in;
         under_start_ff  <= under_start_in;
         under_active_ff <= under_active_in;
         last_change_ff  <= last_change_in;
         last_frame_ff   <= last_frame_in;
         degrade_ff      <= degrade_in;
      end
   end

endmodule

/* sv/rsbg_outreg.sv */
// ----------------------------------------------------------------------------
// Render scale budget governor result register
// Holds one result beat until the response channel takes it.
// ----------------------------------------------------------------------------
module rsbg_outreg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  rsbg_pkg::rsp_type  result,
   output logic               free,
   rsbg_rsp_if.source         rsp
);
   import rsbg_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign free = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp.valid              = valid_ff;
   assign rsp.decision           = data_ff.decision;
   assign rsp.cause              = data_ff.cause;
   assign rsp.previous_scale     = data_ff.previous_scale;
   assign rsp.new_scale          = data_ff.new_scale;
   assign rsp.echoed_frame_index = data_ff.echoed_frame_index;

endmodule

/* sv/render_scale_budget_governor_unit.sv */
// ----------------------------------------------------------------------------
// Render scale budget governor unit
// Steps a render scale from frame-time samples under sustain and cooldown rules.
// ----------------------------------------------------------------------------
// The unit takes one request beat per clock cycle unless the response stalls,
// and returns one response beat for each GPU sample via the input register
// and the result register; a restart beat updates the timers and returns
// nothing. The rate is set by the loop through the decision logic and the
// governor state registers, which are updated as each beat leaves the input
// register. A stalled response holds in the result register while the next
// beat still enters. Register writes pass the CSR and then the limit registers.
module render_scale_budget_governor_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   rsbg_req_if.sink    req,
   rsbg_rsp_if.source  rsp
);
   import rsbg_pkg::*;

`include "render_scale_budget_governor_unit_assert.svh"

   cfg_type cfg;
   req_type in_ff;
   logic    in_valid_ff;
   rsp_type result;
   logic    out_free;
   logic    fire;
   logic    load;

   assign fire      = in_valid_ff && out_free;
   assign load      = fire && (in_ff.action == ACT_SAMPLE);
   assign req.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_ff <= '{action: req.action, sample_valid: req.sample_valid,
                    frame_time_us: req.frame_time_us, frame_index: req.frame_index,
                    now_us: req.now_us};
      end
   end

   rsbg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rsbg_governor u_governor (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .item   (in_ff),
      .result (result)
   );

   rsbg_outreg u_outreg (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .result (result),
      .free   (out_free),
      .rsp    (rsp)
   );

   `RSBG_ASSERT_IMPL(a_keep_holds_scale, clock, reset, rsp.valid && rsp.decision != DEC_DECREASE && rsp.decision != DEC_INCREASE, rsp.new_scale == rsp.previous_scale)
   `RSBG_ASSERT_IMPL(a_decrease_lowers, clock, reset, rsp.valid && rsp.decision == DEC_DECREASE, rsp.new_scale < rsp.previous_scale)
   `RSBG_ASSERT_IMPL(a_increase_raises, clock, reset, rsp.valid && rsp.decision == DEC_INCREASE, rsp.new_scale > rsp.previous_scale)
   `RSBG_ASSERT_NEXT(a_restart_silent, clock, reset, fire && in_ff.action == ACT_RESTART && !rsp.valid, !rsp.valid)

endmodule
